// File: design/fpbd_pkg.sv
// Shared constants for the fixed-point balance decay block.
// No dependencies; used by the top level and its checker.
package fpbd_pkg;

    localparam int VALUE_W   = 62;
    localparam int SECONDS_W = 28;
    localparam int YEAR_W    = 25;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;

    localparam int TERMS_DEF         = 19;
    localparam int SECONDS_BITS_DEF  = 28;
    localparam int FRACTION_BITS_DEF = 32;

    // ln 2 as unsigned Q0.32
    localparam int          LN2_SHIFT = 32;
    localparam logic [31:0] LN2_Q32   = 32'hB17217F7;

    localparam logic [YEAR_W-1:0] YEAR_RESET = 25'd31556952;

endpackage

// File: design/fpbd_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// No dependencies; instanced by the decay top level.
module fpbd_mul #(
    parameter int MCW = 94,
    parameter int MRW = 60
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MCW-1:0]     mcand,
    input  logic [MRW-1:0]     mplier,
    output logic               done,
    output logic [MCW+MRW-1:0] prod
);

    localparam int CW = $clog2(MRW + 1);

    logic [MCW-1:0] mc_reg;
    logic [MCW-1:0] hi_reg, hi_next;
    logic [MRW-1:0] lo_reg, lo_next;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [MCW:0]   sum;

    always_comb begin
        sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : '0);
        hi_next = sum[MCW:1];
        lo_next = {sum[0], lo_reg[MRW-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(MRW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mc_reg <= mcand;
            hi_reg <= '0;
            lo_reg <= mplier;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// File: design/fpbd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies; instanced by the decay top level.
module fpbd_div #(
    parameter int DW = 122,
    parameter int VW = 95
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          ge;

    always_comb begin
        trial  = {r_reg, q_reg[DW-1]};
        ge     = trial >= {1'b0, dvs_reg};
        r_next = ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift dividend bits out the top, quotient bits in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[DW-2:0], ge};
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: design/fixed_point_balance_decay_top.sv
// Top level of the fixed-point balance decay block: sequencer and result register.
// Depends on fpbd_pkg, fpbd_mul and fpbd_div.
//
// One item is worked at a time through a bit-serial multiplier and a bit-serial divider,
// both retiring one bit per cycle. With XW = SECONDS_BITS+FRACTION_BITS, the multiplier
// operand is MW = max(XW, 32) bits and the divider DW = 62+FRACTION_BITS+SECONDS_BITS. The
// divider forms t = seconds/year, the multiplier scales t by ln 2 to x, each of up to TERMS
// series terms takes a multiply by x and a divide by its index, and a last divide gives
// value/factor. The next beat is taken once the current result has moved into the output
// register, even while that result waits on m_tready.
module fixed_point_balance_decay_top #(
    parameter int TERMS         = fpbd_pkg::TERMS_DEF,
    parameter int SECONDS_BITS  = fpbd_pkg::SECONDS_BITS_DEF,
    parameter int FRACTION_BITS = fpbd_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fpbd_pkg::YEAR_W-1:0]     cfg_wr_data,   // year_seconds
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpbd_pkg::S_TDATA_W-1:0]  s_tdata,       // value[61:0], seconds[89:62]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpbd_pkg::M_TDATA_W-1:0]  m_tdata        // decayed_value[61:0]
);

    localparam int VW_IN = fpbd_pkg::VALUE_W;
    localparam int XW    = SECONDS_BITS + FRACTION_BITS;
    localparam int MCW   = VW_IN + FRACTION_BITS;
    localparam int MRW   = (XW > fpbd_pkg::LN2_SHIFT) ? XW : fpbd_pkg::LN2_SHIFT;
    localparam int DW    = VW_IN + FRACTION_BITS + SECONDS_BITS;
    localparam int FW    = VW_IN + 1 + FRACTION_BITS;
    localparam int IW    = $clog2(TERMS + 1);

    localparam logic [32:0] SMAX    = (33'd1 << SECONDS_BITS) - 33'd1;
    localparam logic [DW:0] CAP_EXT = (DW + 1)'(1) << (VW_IN + FRACTION_BITS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TDIV  = 3'd1;
    localparam logic [2:0] ST_LNMUL = 3'd2;
    localparam logic [2:0] ST_TMUL  = 3'd3;
    localparam logic [2:0] ST_IDIV  = 3'd4;
    localparam logic [2:0] ST_FDIV  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [fpbd_pkg::YEAR_W-1:0] year_reg;
    logic [VW_IN-1:0]            value_reg;
    logic [XW-1:0]               x_reg, x_next;
    logic [FW-1:0]               factor_reg, factor_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [VW_IN-1:0]            res_reg;
    logic                        out_valid_reg;
    logic [VW_IN-1:0]            out_data_reg;

    logic                 mul_start, mul_done;
    logic [MCW-1:0]       mul_mc;
    logic [MRW-1:0]       mul_mr;
    logic [MCW+MRW-1:0]   mul_prod;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_dvd;
    logic [FW-1:0]        div_dvs;
    logic [DW-1:0]        div_quot;

    logic [32:0]                 sec_ext, sec_sat;
    logic [fpbd_pkg::YEAR_W-1:0] year_eff;
    logic [DW:0]                 sum;
    logic                        q_zero, cap_hit, last_term, out_free;

    fpbd_mul #(.MCW(MCW), .MRW(MRW)) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .mcand  (mul_mc),
        .mplier (mul_mr),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    fpbd_div #(.DW(DW), .VW(FW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        sec_ext  = 33'(s_tdata[VW_IN +: fpbd_pkg::SECONDS_W]);
        sec_sat  = (sec_ext > SMAX) ? SMAX : sec_ext;
        year_eff = (year_reg == '0) ? fpbd_pkg::YEAR_W'(1) : year_reg;

        sum       = (DW + 1)'(div_quot) + (DW + 1)'(factor_reg);
        q_zero    = (div_quot == '0);
        cap_hit   = (sum >= CAP_EXT);
        last_term = q_zero || cap_hit || (idx_reg == IW'(TERMS));

        state_next  = state_reg;
        x_next      = x_reg;
        factor_next = factor_reg;
        idx_next    = idx_reg;
        mul_start   = 1'b0;
        mul_mc      = '0;
        mul_mr      = '0;
        div_start   = 1'b0;
        div_dvd     = '0;
        div_dvs     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    div_start  = 1'b1;
                    div_dvd    = DW'(sec_sat) << FRACTION_BITS;
                    div_dvs    = FW'(year_eff);
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    mul_mc     = MCW'(fpbd_pkg::LN2_Q32);
                    mul_mr     = MRW'(div_quot[XW-1:0]);
                    state_next = ST_LNMUL;
                end
            end
            ST_LNMUL: begin
                if (mul_done) begin
                    x_next      = mul_prod[fpbd_pkg::LN2_SHIFT +: XW];
                    factor_next = FW'(1) << FRACTION_BITS;
                    idx_next    = IW'(1);
                    mul_start   = 1'b1;
                    mul_mc      = MCW'(1) << FRACTION_BITS;
                    mul_mr      = MRW'(x_next);
                    state_next  = ST_TMUL;
                end
            end
            ST_TMUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_dvd    = mul_prod[FRACTION_BITS +: DW];
                    div_dvs    = FW'(idx_reg);
                    state_next = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (div_done) begin
                    // drop a zero term, clamp at the cap
                    if (q_zero) begin
                        factor_next = factor_reg;
                    end else if (cap_hit) begin
                        factor_next = FW'(CAP_EXT);
                    end else begin
                        factor_next = sum[FW-1:0];
                    end
                    if (last_term) begin
                        div_start  = 1'b1;
                        div_dvd    = DW'(value_reg) << FRACTION_BITS;
                        div_dvs    = factor_next;
                        state_next = ST_FDIV;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        mul_start  = 1'b1;
                        mul_mc     = div_quot[MCW-1:0];
                        mul_mr     = MRW'(x_reg);
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_FDIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            year_reg      <= fpbd_pkg::YEAR_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                year_reg <= cfg_wr_data;
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        factor_reg <= factor_next;
        idx_reg    <= idx_next;
        if (state_reg == ST_IDLE && s_tvalid) begin
            value_reg <= s_tdata[VW_IN-1:0];
        end
        if (state_reg == ST_FDIV && div_done) begin
            res_reg <= div_quot[VW_IN-1:0];
        end
        if (state_reg == ST_OUT && out_free) begin
            out_data_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fpbd_pkg::M_TDATA_W'(out_data_reg);

endmodule

// File: design/fpbd_checker.sv
// Port-level checker for the balance decay top level, with its bind.
// Depends on fpbd_pkg and fixed_point_balance_decay_top.
module fpbd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fpbd_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    ap_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: input closes right after a beat is taken
    ap_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("input taken while busy or result too early");

    ap_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[fpbd_pkg::M_TDATA_W-1:fpbd_pkg::VALUE_W] == '0)
        else $error("result padding bits not zero");

endmodule

bind fixed_point_balance_decay_top fpbd_checker u_fpbd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: dv/tb.sv
// Testbench for fixed_point_balance_decay_top: directed and random balance/time beats,
// checked against an in-bench fixed-point decay predictor.
// Depends on fpbd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int          FRAC     = fpbd_pkg::FRACTION_BITS_DEF;
    localparam int          N_TERMS  = fpbd_pkg::TERMS_DEF;
    localparam int          WDOG_MAX = 40000;
    localparam logic [61:0] VALUE_MAX = {62{1'b1}};
    localparam logic [27:0] SEC_MAX   = {28{1'b1}};
    localparam logic [24:0] YEAR_MAX  = {25{1'b1}};

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [fpbd_pkg::YEAR_W-1:0]      cfg_wr_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [fpbd_pkg::S_TDATA_W-1:0]   s_tdata;    // value[61:0], seconds[89:62], zero pad
    logic                             m_tvalid;
    logic                             m_tready;
    logic [fpbd_pkg::M_TDATA_W-1:0]   m_tdata;    // decayed_value[61:0], zero pad

    fixed_point_balance_decay_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [fpbd_pkg::YEAR_W-1:0] year_len;
    logic [61:0]       decay_q[$];
    int                mismatches;
    int                errors;
    int                beats_in;
    int                beats_out;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                wdog;

    initial begin
        aclk = 1'b0;
    end
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Decay predictor: value * 2^F / (2^t Taylor sum), wide enough that nothing wraps.
    function automatic logic [61:0] decayed(logic [61:0] value, logic [27:0] secs,
                                            logic [24:0] year);
        logic [255:0] yr;
        logic [255:0] t;
        logic [255:0] x;
        logic [255:0] term;
        logic [255:0] factor;
        logic [255:0] cap;
        logic [255:0] q;
        yr     = (year == 0) ? 256'd1 : 256'(year);
        cap    = 256'd1 << (62 + FRAC);
        t      = (256'(secs) << FRAC) / yr;
        x      = (t * 256'(fpbd_pkg::LN2_Q32)) >> fpbd_pkg::LN2_SHIFT;
        factor = 256'd1 << FRAC;
        term   = factor;
        for (int i = 1; i <= N_TERMS; i++) begin
            term = ((term * x) >> FRAC) / 256'(i);
            if (term == 0) break;
            factor = factor + term;
            if (factor >= cap) begin
                factor = cap;
                break;
            end
        end
        q = (256'(value) << FRAC) / factor;
        return q[61:0];
    endfunction

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_out <= beats_out + 1;
            if (decay_q.size() == 0) begin
                errors <= errors + 1;
                if (mismatches + errors < 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                logic [61:0] exp_v;
                exp_v = decay_q.pop_front();
                if (m_tdata[61:0] !== exp_v) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h got %h", exp_v, m_tdata[61:0]);
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("timeout with %0d results outstanding", decay_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_balance(logic [61:0] value, logic [27:0] secs);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, secs, value};
        do @(posedge aclk); while (!s_tready);
        decay_q.push_back(decayed(value, secs, year_len));
        beats_in++;
    endtask

    // Hold the input low until every result has come out.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (decay_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_year(logic [24:0] year);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= year;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        year_len = year;
    endtask

    task automatic test_field_extremes;
        send_balance(62'd0, 28'd0);
        send_balance(VALUE_MAX, 28'd0);
        send_balance(VALUE_MAX, SEC_MAX);
        send_balance(62'd1, 28'd1);
        send_balance(VALUE_MAX, 28'(year_len));
        send_balance(62'h2AAA_AAAA_AAAA_AAAA, 28'h5555555);
        send_balance(62'h1555_5555_5555_5555, 28'hAAAAAAA);
    endtask

    task automatic test_year_extremes;
        // year of one: at the largest time the factor saturates and the result goes to zero
        write_year(25'd1);
        send_balance(VALUE_MAX, SEC_MAX);
        send_balance(VALUE_MAX, 28'd1);
        send_balance(VALUE_MAX, 28'd60);
        // zero year length behaves as one
        write_year(25'd0);
        send_balance(VALUE_MAX, 28'd2);
        send_balance(62'd12345, 28'd0);
        write_year(YEAR_MAX);
        send_balance(VALUE_MAX, SEC_MAX);
        send_balance(VALUE_MAX, 28'd1);
        send_balance(62'd0, SEC_MAX);
        write_year(fpbd_pkg::YEAR_RESET);
    endtask

    task automatic test_random(int count);
        logic [61:0] v;
        logic [27:0] sec;
        for (int n = 0; n < count; n++) begin
            v = 62'({$urandom, $urandom});
            case ($urandom_range(3))
                0: v = v >> $urandom_range(61);
                1: v = VALUE_MAX - 62'($urandom_range(3));
                default: ;
            endcase
            case ($urandom_range(3))
                0: sec = 28'($urandom);
                1: sec = 28'($urandom_range(2 * 1 + year_len * 3));
                2: sec = 28'($urandom_range(200));
                default: sec = 28'($urandom_range(year_len));
            endcase
            send_balance(v, sec);
            if (n % 37 == 36) drain();
        end
    endtask

    initial begin
        logic [24:0] years[5];
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        mismatches  = 0;
        errors      = 0;
        beats_in    = 0;
        beats_out   = 0;
        wdog        = 0;
        tx_idle_pct = 17;
        rx_idle_pct = 64;
        year_len    = fpbd_pkg::YEAR_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_year_extremes();

        years = '{fpbd_pkg::YEAR_RESET, 25'd86400, 25'd1, YEAR_MAX,
                  25'($urandom_range(2, 5000000))};
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 64 : 0;
            rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 17 : 0;
            for (int k = 0; k < 5; k++) begin
                write_year(years[(k + phase) % 5]);
                test_random(27);
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d balance beats in, %0d results out, year lengths 0 to max",
                 beats_in, beats_out);
        $display("sender/receiver stalls swapped across phases, %0d mismatches, %0d strays",
                 mismatches, errors);
        if (mismatches == 0 && errors == 0 && decay_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
